/* hw/rtl/sha1_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-1 hasher package
// Shared constants, command and status types for the controller and datapath.
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam logic [4:0][31:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [2:0] LAST_WORD  = 3'd4;

  // Source of the byte shifted into the block buffer.
  localparam logic [1:0] BSEL_INPUT = 2'd0;
  localparam logic [1:0] BSEL_MARK  = 2'd1;
  localparam logic [1:0] BSEL_ZERO  = 2'd2;
  localparam logic [1:0] BSEL_LEN   = 2'd3;

  typedef struct packed {
    logic       shift_byte;
    logic [1:0] byte_sel;
    logic       count_byte;
    logic       load_work;
    logic       round_en;
    logic [1:0] round_grp;
    logic       add_hash;
    logic       clear_msg;
    logic [2:0] word_idx;
  } cmd_t;

  typedef struct packed {
    logic pos_last;
    logic pos_lt56;
  } status_t;

  function automatic logic [31:0] round_k(input logic [1:0] grp);
    logic [31:0] k;
    unique case (grp)
      2'd0:    k = 32'h5A827999;
      2'd1:    k = 32'h6ED9EBA1;
      2'd2:    k = 32'h8F1BBCDC;
      default: k = 32'hCA62C1D6;
    endcase
    return k;
  endfunction

endpackage

/* hw/rtl/sha1_in_if.sv */
// ----------------------------------------------------------------------------
// SHA-1 input channel
// Valid/ready channel carrying one message byte and its control flags.
// ----------------------------------------------------------------------------
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, output data_byte, output byte_present,
                  output end_of_message, input ready);
  modport sink (input valid, input data_byte, input byte_present,
                input end_of_message, output ready);
endinterface

/* hw/rtl/sha1_out_if.sv */
// ----------------------------------------------------------------------------
// SHA-1 result channel
// Valid/ready channel carrying one digest word with its index.
// ----------------------------------------------------------------------------
interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        last_word;

  modport source (output valid, output digest_word, output word_number,
                  output last_word, input ready);
  modport sink (input valid, input digest_word, input word_number,
                input last_word, output ready);
endinterface

/* hw/rtl/sha1_dp.sv */
// ----------------------------------------------------------------------------
// SHA-1 datapath
// Block shift buffer, rolling schedule, round unit, chaining hash and length.
// ----------------------------------------------------------------------------
module sha1_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  sha1_pkg::cmd_t   cmd,
  input  logic [7:0]       data_byte,
  output sha1_pkg::status_t status,
  output logic [31:0]      digest_word
);

  logic [511:0] blk_r, blk_nxt;
  logic [5:0]   pos_r, pos_nxt;
  logic [63:0]  len_r, len_nxt;
  logic [31:0]  h_r [5];
  logic [31:0]  h_nxt [5];
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [31:0]  a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [7:0]   byte_in;
  logic [31:0]  sched_x, sched_new, w0, f, tmp;

  assign status.pos_last = (pos_r == 6'd63);
  assign status.pos_lt56 = (pos_r[5:3] != 3'd7);

  always_comb begin
    unique case (cmd.byte_sel)
      sha1_pkg::BSEL_INPUT: byte_in = data_byte;
      sha1_pkg::BSEL_MARK:  byte_in = sha1_pkg::PAD_MARK;
      sha1_pkg::BSEL_ZERO:  byte_in = 8'h00;
      default:              byte_in = len_r[{~pos_r[2:0], 3'b000} +: 8];
    endcase
  end

  assign w0        = blk_r[511:480];
  assign sched_x   = blk_r[95:64] ^ blk_r[255:224] ^ blk_r[447:416] ^ w0;
  assign sched_new = {sched_x[30:0], sched_x[31]};

  always_comb begin
    unique case (cmd.round_grp)
      2'd0:    f = (b_r & c_r) | (~b_r & d_r);
      2'd2:    f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      default: f = b_r ^ c_r ^ d_r;
    endcase
  end

  assign tmp = {a_r[26:0], a_r[31:27]} + f + e_r + w0 + sha1_pkg::round_k(cmd.round_grp);

  always_comb begin
    blk_nxt = blk_r;
    pos_nxt = pos_r;
    len_nxt = len_r;
    a_nxt = a_r;
    b_nxt = b_r;
    c_nxt = c_r;
    d_nxt = d_r;
    e_nxt = e_r;
    for (int i = 0; i < 5; i++) begin
      h_nxt[i] = h_r[i];
    end
    if (cmd.shift_byte) begin
      blk_nxt = {blk_r[503:0], byte_in};
      pos_nxt = pos_r + 6'd1;
    end else if (cmd.round_en) begin
      blk_nxt = {blk_r[479:0], sched_new};
    end
    if (cmd.clear_msg) begin
      len_nxt = '0;
    end else if (cmd.count_byte) begin
      len_nxt = len_r + 64'd8;
    end
    if (cmd.load_work) begin
      a_nxt = h_r[0];
      b_nxt = h_r[1];
      c_nxt = h_r[2];
      d_nxt = h_r[3];
      e_nxt = h_r[4];
    end else if (cmd.round_en) begin
      a_nxt = tmp;
      b_nxt = a_r;
      c_nxt = {b_r[1:0], b_r[31:2]};
      d_nxt = c_r;
      e_nxt = d_r;
    end
    if (cmd.clear_msg) begin
      for (int i = 0; i < 5; i++) begin
        h_nxt[i] = sha1_pkg::H_INIT[i];
      end
    end else if (cmd.add_hash) begin
      h_nxt[0] = h_r[0] + a_r;
      h_nxt[1] = h_r[1] + b_r;
      h_nxt[2] = h_r[2] + c_r;
      h_nxt[3] = h_r[3] + d_r;
      h_nxt[4] = h_r[4] + e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      len_r <= '0;
      for (int i = 0; i < 5; i++) begin
        h_r[i] <= sha1_pkg::H_INIT[i];
      end
    end else begin
      pos_r <= pos_nxt;
      len_r <= len_nxt;
      for (int i = 0; i < 5; i++) begin
        h_r[i] <= h_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    e_r   <= e_nxt;
  end

  always_comb begin
    unique case (cmd.word_idx)
      3'd0:    digest_word = h_r[0];
      3'd1:    digest_word = h_r[1];
      3'd2:    digest_word = h_r[2];
      3'd3:    digest_word = h_r[3];
      3'd4:    digest_word = h_r[4];
      default: digest_word = h_r[0];
    endcase
  end

endmodule

/* hw/rtl/sha1_ctrl.sv */
// ----------------------------------------------------------------------------
// SHA-1 controller
// Sequences byte intake, padding, the 80 rounds and the digest word readout.
// ----------------------------------------------------------------------------
module sha1_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_byte_present,
  input  logic              in_end_of_message,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        word_number,
  output logic              last_word,
  input  sha1_pkg::status_t status,
  output sha1_pkg::cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [6:0] rnd_r, rnd_nxt;
  logic [2:0] word_r, word_nxt;
  logic       eom_r, eom_nxt;
  logic       pad_r, pad_nxt;
  logic       mark_r, mark_nxt;
  logic       lenok_r, lenok_nxt;
  logic [1:0] grp;

  always_comb begin
    priority if (rnd_r < 7'd20) begin
      grp = 2'd0;
    end else if (rnd_r < 7'd40) begin
      grp = 2'd1;
    end else if (rnd_r < 7'd60) begin
      grp = 2'd2;
    end else begin
      grp = 2'd3;
    end
  end

  assign word_number = word_r;
  assign last_word   = (word_r == sha1_pkg::LAST_WORD);

  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    word_nxt  = word_r;
    eom_nxt   = eom_r;
    pad_nxt   = pad_r;
    mark_nxt  = mark_r;
    lenok_nxt = lenok_r;
    cmd       = '0;
    cmd.byte_sel  = sha1_pkg::BSEL_INPUT;
    cmd.round_grp = grp;
    cmd.word_idx  = word_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_byte_present) begin
            cmd.shift_byte = 1'b1;
            cmd.count_byte = 1'b1;
          end
          if (in_byte_present && status.pos_last) begin
            state_nxt     = ST_ROUND;
            cmd.load_work = 1'b1;
            rnd_nxt       = '0;
            eom_nxt       = in_end_of_message;
          end else if (in_end_of_message) begin
            state_nxt = ST_PAD;
            pad_nxt   = 1'b1;
            mark_nxt  = 1'b0;
            lenok_nxt = 1'b0;
          end
        end
      end
      ST_PAD: begin
        cmd.shift_byte = 1'b1;
        if (!mark_r) begin
          cmd.byte_sel = sha1_pkg::BSEL_MARK;
          mark_nxt     = 1'b1;
          lenok_nxt    = status.pos_lt56;
        end else if (lenok_r && !status.pos_lt56) begin
          cmd.byte_sel = sha1_pkg::BSEL_LEN;
        end else begin
          cmd.byte_sel = sha1_pkg::BSEL_ZERO;
        end
        if (status.pos_last) begin
          state_nxt     = ST_ROUND;
          cmd.load_work = 1'b1;
          rnd_nxt       = '0;
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        if (rnd_r == sha1_pkg::LAST_ROUND) begin
          state_nxt = ST_ADD;
          rnd_nxt   = '0;
        end else begin
          rnd_nxt = rnd_r + 7'd1;
        end
      end
      ST_ADD: begin
        cmd.add_hash = 1'b1;
        if (pad_r) begin
          if (lenok_r) begin
            state_nxt = ST_OUT;
            word_nxt  = '0;
          end else begin
            state_nxt = ST_PAD;
            lenok_nxt = 1'b1;
          end
        end else if (eom_r) begin
          state_nxt = ST_PAD;
          eom_nxt   = 1'b0;
          pad_nxt   = 1'b1;
          mark_nxt  = 1'b0;
          lenok_nxt = 1'b0;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (word_r == sha1_pkg::LAST_WORD) begin
            cmd.clear_msg = 1'b1;
            state_nxt     = ST_IDLE;
            pad_nxt       = 1'b0;
            word_nxt      = '0;
          end else begin
            word_nxt = word_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r   <= '0;
      word_r  <= '0;
      eom_r   <= 1'b0;
      pad_r   <= 1'b0;
      mark_r  <= 1'b0;
      lenok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      word_r  <= word_nxt;
      eom_r   <= eom_nxt;
      pad_r   <= pad_nxt;
      mark_r  <= mark_nxt;
      lenok_r <= lenok_nxt;
    end
  end

  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    rnd_r <= sha1_pkg::LAST_ROUND)
    else $error("Round counter ran past the last round.");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("Input and result channels are open at once.");

  a_rounds_to_add: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && rnd_r == sha1_pkg::LAST_ROUND) |=> (state_r == ST_ADD))
    else $error("Hash update did not follow the last round.");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && last_word) |=> (in_ready && !pad_r))
    else $error("Block did not return to idle after the final digest word.");

endmodule

/* hw/rtl/sha1_byte_stream_hasher.sv */
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher
// Hashes a byte message and returns the five digest words H0 through H4.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload                                  Transfer
//  in_if    sink       data_byte, byte_present, end_of_message  valid && ready
//  out_if   source     digest_word, word_number, last_word      valid && ready
//
// A message byte is taken on each transfer while the block is idle.
// The 64th byte of a block starts the rounds and the hash update, during which
// no transfer is taken; the block has a single round unit.
// End of message shifts padding bytes one per cycle up to the block end,
// compresses one or two blocks, then offers five digest words.
// A stalled result holds the block; no new input is taken until the last word.
// Reset is synchronous and restores the initial hash and a zero length.
module sha1_byte_stream_hasher (
  input logic         clk,
  input logic         rst_n,
  sha1_in_if.sink     in_if,
  sha1_out_if.source  out_if
);

  sha1_pkg::cmd_t    cmd;
  sha1_pkg::status_t status;

  sha1_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_if.valid),
    .in_byte_present   (in_if.byte_present),
    .in_end_of_message (in_if.end_of_message),
    .in_ready          (in_if.ready),
    .out_valid         (out_if.valid),
    .out_ready         (out_if.ready),
    .word_number       (out_if.word_number),
    .last_word         (out_if.last_word),
    .status            (status),
    .cmd               (cmd)
  );

  sha1_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_if.data_byte),
    .status      (status),
    .digest_word (out_if.digest_word)
  );

endmodule

/* dv/tb_sha1_byte_stream_hasher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher testbench
// Sends directed and random byte messages, some of them with idle items
// between the bytes, and checks every digest word. A digest tracker follows
// the hash state for each input transfer. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_sha1_byte_stream_hasher;

  localparam int STALL_PCT      = 21;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  num;
    logic        last;
  } digest_entry_t;

  class sha1_digest_tracker;
    logic [31:0]   chain [5];
    logic [7:0]    block [64];
    int unsigned   fill;
    logic [63:0]   bit_count;
    digest_entry_t due_words [$];
    int unsigned   mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 5; i++) begin
        chain[i] = sha1_pkg::H_INIT[i];
      end
      fill = 0;
      bit_count = '0;
    endfunction

    function void compress();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, t;
      int s;
      for (int i = 0; i < 16; i++) begin
        w[i] = {block[4*i], block[4*i+1], block[4*i+2], block[4*i+3]};
      end
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int r = 0; r < 80; r++) begin
        s = r & 15;
        if (r >= 16) begin
          t = w[(s + 13) & 15] ^ w[(s + 8) & 15] ^ w[(s + 2) & 15] ^ w[s];
          w[s] = {t[30:0], t[31]};
        end
        if (r < 20) begin
          f = (b & c) | (~b & d);
          k = 32'h5A827999;
        end else if (r < 40) begin
          f = b ^ c ^ d;
          k = 32'h6ED9EBA1;
        end else if (r < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = 32'h8F1BBCDC;
        end else begin
          f = b ^ c ^ d;
          k = 32'hCA62C1D6;
        end
        t = {a[26:0], a[31:27]} + f + e + w[s] + k;
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
      fill = 0;
    endfunction

    function void finish_digest();
      block[fill] = sha1_pkg::PAD_MARK;
      fill = fill + 1;
      if (fill > 56) begin
        while (fill < 64) begin
          block[fill] = 8'h00;
          fill = fill + 1;
        end
        compress();
      end
      while (fill < 56) begin
        block[fill] = 8'h00;
        fill = fill + 1;
      end
      for (int i = 0; i < 8; i++) begin
        block[56 + i] = bit_count[63 - 8*i -: 8];
      end
      compress();
      for (int n = 0; n < 5; n++) begin
        due_words.push_back('{chain[n], 3'(n), 3'(n) == sha1_pkg::LAST_WORD});
      end
      restart();
    endfunction

    function void take_item(logic [7:0] data, logic present, logic eom);
      if (present) begin
        block[fill] = data;
        fill = fill + 1;
        bit_count += 64'd8;
        if (fill == 64) begin
          compress();
        end
      end
      if (eom) begin
        finish_digest();
      end
    endfunction

    function void report(string what, logic [31:0] exp_val, logic [31:0] got_val);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("[%0t] MISMATCH %s: expected %h, got %h", $time, what, exp_val, got_val);
      end
    endfunction

    function void match_word(logic [31:0] word, logic [2:0] num, logic last);
      digest_entry_t want;
      if (due_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("[%0t] MISMATCH unexpected result word %h index %0d", $time, word, num);
        end
        return;
      end
      want = due_words.pop_front();
      if (word !== want.word) report("digest_word", want.word, word);
      if (num !== want.num) report("word_number", 32'(want.num), 32'(num));
      if (last !== want.last) report("last_word", 32'(want.last), 32'(last));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   quiet_run;
  int   stuck_cycles;
  int   random_bytes;
  int   random_msgs;
  int   msg_len;

  sha1_in_if  in_ch ();
  sha1_out_if out_ch ();

  sha1_digest_tracker tracker = new();

  sha1_byte_stream_hasher DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= quiet_run || ($urandom_range(99) >= STALL_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      tracker.take_item(in_ch.data_byte, in_ch.byte_present, in_ch.end_of_message);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tracker.match_word(out_ch.digest_word, out_ch.word_number, out_ch.last_word);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL sha1_byte_stream_hasher");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] data, input logic present, input logic eom);
    while (!quiet_run && $urandom_range(99) < STALL_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= data;
    in_ch.byte_present   <= present;
    in_ch.end_of_message <= eom;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_message(input int len, input bit end_on_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 5) begin
        send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      end
      send_item(8'($urandom_range(255)), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte || len == 0) begin
      send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    end
    random_bytes += len;
    random_msgs++;
  endtask

  initial begin
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.data_byte      <= 8'h00;
    in_ch.byte_present   <= 1'b0;
    in_ch.end_of_message <= 1'b0;
    quiet_run    = 1'b0;
    random_bytes = 0;
    random_msgs  = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // The empty message, then an idle item that must leave the state alone.
    send_item(8'hA5, 1'b0, 1'b1);
    send_item(8'h3C, 1'b0, 1'b0);
    // A short message whose last byte ends it in the same transfer.
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // Extreme byte values, an idle item inside the message and an end without a byte.
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hC3, 1'b0, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);

    // A full block ended by its last byte, sent without any stalls.
    quiet_run = 1'b1;
    send_message(64, 1'b1);
    quiet_run = 1'b0;
    // A tail too long for the length field, so the padding spills into a second block.
    send_message(56, 1'b0);
    while (random_msgs < 3) begin
      msg_len = $urandom_range(9);
      send_message(msg_len, 1'($urandom_range(1)));
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);

    while (tracker.due_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0) begin
      $display("PASS sha1_byte_stream_hasher");
    end else begin
      $display("FAIL sha1_byte_stream_hasher");
    end
    $finish;
  end

endmodule
